[rtl/core/slbh_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package slbh_pkg;

   typedef struct packed {
      logic        mode;
      logic [63:0] frame_sequence;
      logic [63:0] present_time;
      logic [63:0] total_time;
      logic        total_ok;
      logic [63:0] cpu_encode_time;
      logic [63:0] queue_wait_time;
      logic [63:0] gpu_exec_time;
      logic [63:0] compositor_time;
      logic        parts_ok;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic        entry_valid;
      logic [63:0] out_sequence;
      logic [63:0] out_present_time;
      logic [63:0] out_total_time;
      logic        out_total_ok;
      logic [63:0] out_cpu_encode_time;
      logic [63:0] out_queue_wait_time;
      logic [63:0] out_gpu_exec_time;
      logic [63:0] out_compositor_time;
      logic        out_parts_ok;
      logic        last_entry;
   } rsp_type;

   typedef struct packed {
      logic [63:0] seq;
      logic [63:0] present;
      logic [63:0] total;
      logic [63:0] cpu;
      logic [63:0] queue;
      logic [63:0] gpu;
      logic [63:0] comp;
      logic        total_ok;
      logic        parts_ok;
   } entry_type;

   localparam int unsigned EntryWidth = $bits(entry_type);

endpackage
`default_nettype wire

[rtl/core/sorted_bounded_latency_history.sv]
// Sorted history of frame-latency records, held in one entry memory.
// The request channel (req_valid, req_stall, req_data) carries one record
// or dump transaction; the response channel (rsp_valid, rsp_stall, rsp_data)
// returns its results. A transaction is taken when valid is high and stall
// is low. One request is worked on at a time; req_stall is high meanwhile.
// A record scans the stored entries in order (duplicate check and sorted
// position), shifts the entries on one side of the insertion point one at
// a time, writes the new entry and then answers, its pace set by the single
// read and single write port of the memory. A dump returns each entry in
// turn (memory read, then response register), or one empty response.
// Reset clears the entry count and the control state; the memory contents
// are not cleared, as only entries below the count are ever read.
// When the receiver stalls, the response register holds its transaction and
// the block waits before loading the next one; a request may still be taken
// while a finished response waits.
`timescale 1ns / 1ps
`default_nettype none
module sorted_bounded_latency_history
   import slbh_pkg::*;
#(
   parameter int unsigned CAPACITY = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int unsigned AW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CapCount = CW'(CAPACITY);
   localparam logic [CW-1:0] One = CW'(1);

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_SCAN     = 7'b0000010,
      ST_DECIDE   = 7'b0000100,
      ST_SHIFT    = 7'b0001000,
      ST_WRITE    = 7'b0010000,
      ST_RESP     = 7'b0100000,
      ST_DUMP_RD  = 7'b1000000
   } state_type;

   state_type       state_ff, state_in;
   logic            dump_out_ff, dump_out_in;
   logic [CW-1:0]   count_ff, count_in;
   req_type         req_ff, req_in;
   logic [CW-1:0]   idx_ff, idx_in;
   logic            cmp_pend_ff, cmp_pend_in;
   logic            cmp_first_ff, cmp_first_in;
   logic            dup_ff, dup_in;
   logic [CW-1:0]   before_ff, before_in;
   logic            first_before_ff, first_before_in;
   logic            full_ff, full_in;
   logic            pend_ff, pend_in;
   logic [AW-1:0]   dest_ff, dest_in;
   logic [CW-1:0]   left_ff, left_in;
   logic [AW-1:0]   ins_ff, ins_in;
   logic            acc_ff, acc_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;

   logic            wr_en, rd_en;
   logic [AW-1:0]   wr_addr, rd_addr;
   entry_type       wr_data, rd_data;
   logic            out_free, hit_before, reject;

   slbh_ram #(
      .WIDTH (EntryWidth),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign hit_before = (rd_data.present < req_ff.present_time) ||
      ((rd_data.present == req_ff.present_time) && (rd_data.seq < req_ff.frame_sequence));
   assign reject = (req_ff.frame_sequence == 64'd0) || (req_ff.present_time == 64'd0) ||
      dup_ff || ((count_ff == CapCount) && !first_before_ff);

   always_comb begin
      state_in        = state_ff;
      dump_out_in     = dump_out_ff;
      count_in        = count_ff;
      req_in          = req_ff;
      idx_in          = idx_ff;
      cmp_pend_in     = 1'b0;
      cmp_first_in    = 1'b0;
      dup_in          = dup_ff;
      before_in       = before_ff;
      first_before_in = first_before_ff;
      full_in         = full_ff;
      pend_in         = 1'b0;
      dest_in         = dest_ff;
      left_in         = left_ff;
      ins_in          = ins_ff;
      acc_in          = acc_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_in          = rsp_ff;
      rd_en           = 1'b0;
      rd_addr         = idx_ff[AW-1:0];
      wr_en           = 1'b0;
      wr_addr         = dest_ff;
      wr_data         = rd_data;
      req_stall       = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               req_in    = req_data;
               idx_in    = '0;
               dup_in    = 1'b0;
               before_in = '0;
               acc_in    = 1'b0;
               if (!req_data.mode) begin
                  state_in = ST_SCAN;
               end else if (count_ff == '0) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_DUMP_RD;
               end
            end
         end
         ST_SCAN: begin
            if (idx_ff < count_ff) begin
               rd_en        = 1'b1;
               idx_in       = idx_ff + One;
               cmp_pend_in  = 1'b1;
               cmp_first_in = (idx_ff == '0);
            end
            if (cmp_pend_ff) begin
               if (rd_data.seq == req_ff.frame_sequence) begin
                  dup_in = 1'b1;
               end
               if (hit_before) begin
                  before_in = before_ff + One;
               end
               if (cmp_first_ff) begin
                  first_before_in = hit_before;
               end
            end
            if (!(idx_ff < count_ff) && !cmp_pend_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            full_in = (count_ff == CapCount);
            if (reject) begin
               acc_in   = 1'b0;
               state_in = ST_RESP;
            end else if (count_ff == CapCount) begin
               left_in  = before_ff - One;
               idx_in   = One;
               ins_in   = AW'(before_ff - One);
               state_in = ST_SHIFT;
            end else begin
               left_in  = count_ff - before_ff;
               idx_in   = count_ff - One;
               ins_in   = AW'(before_ff);
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (left_ff != '0) begin
               rd_en   = 1'b1;
               left_in = left_ff - One;
               pend_in = 1'b1;
               if (full_ff) begin
                  idx_in  = idx_ff + One;
                  dest_in = AW'(idx_ff - One);
               end else begin
                  idx_in  = idx_ff - One;
                  dest_in = AW'(idx_ff + One);
               end
            end
            if (pend_ff) begin
               wr_en = 1'b1;
            end
            if ((left_ff == '0) && !pend_ff) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            wr_en            = 1'b1;
            wr_addr          = ins_ff;
            wr_data.seq      = req_ff.frame_sequence;
            wr_data.present  = req_ff.present_time;
            wr_data.total    = req_ff.total_time;
            wr_data.cpu      = req_ff.cpu_encode_time;
            wr_data.queue    = req_ff.queue_wait_time;
            wr_data.gpu      = req_ff.gpu_exec_time;
            wr_data.comp     = req_ff.compositor_time;
            wr_data.total_ok = req_ff.total_ok;
            wr_data.parts_ok = req_ff.parts_ok;
            if (!full_ff) begin
               count_in = count_ff + One;
            end
            acc_in   = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in              = '0;
               rsp_in.accepted     = acc_ff;
               rsp_in.last_entry   = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         ST_DUMP_RD: begin
            if (!dump_out_ff) begin
               rd_en       = 1'b1;
               dump_out_in = 1'b1;
            end else if (out_free) begin
               rsp_valid_in                   = 1'b1;
               rsp_in.accepted                = 1'b0;
               rsp_in.entry_valid             = 1'b1;
               rsp_in.out_sequence            = rd_data.seq;
               rsp_in.out_present_time        = rd_data.present;
               rsp_in.out_total_time          = rd_data.total;
               rsp_in.out_total_ok            = rd_data.total_ok;
               rsp_in.out_cpu_encode_time     = rd_data.cpu;
               rsp_in.out_queue_wait_time     = rd_data.queue;
               rsp_in.out_gpu_exec_time       = rd_data.gpu;
               rsp_in.out_compositor_time     = rd_data.comp;
               rsp_in.out_parts_ok            = rd_data.parts_ok;
               rsp_in.last_entry              = (idx_ff + One == count_ff);
               idx_in                         = idx_ff + One;
               dump_out_in                    = 1'b0;
               if (idx_ff + One == count_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dump_out_ff  <= 1'b0;
         count_ff     <= '0;
         cmp_pend_ff  <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dump_out_ff  <= dump_out_in;
         count_ff     <= count_in;
         cmp_pend_ff  <= cmp_pend_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff          <= req_in;
      idx_ff          <= idx_in;
      cmp_first_ff    <= cmp_first_in;
      dup_ff          <= dup_in;
      before_ff       <= before_in;
      first_before_ff <= first_before_in;
      full_ff         <= full_in;
      dest_ff         <= dest_in;
      left_ff         <= left_in;
      ins_ff          <= ins_in;
      acc_ff          <= acc_in;
      rsp_ff          <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

[rtl/core/slbh_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module slbh_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire
